// File: hw/rtl/dte_pkg.sv
`default_nettype none
package dte_pkg;

   localparam int BaseW         = 16;
   localparam int SymW          = 5;
   localparam int KeyW          = 60;
   localparam int LenW          = 4;
   localparam int ValueW        = 11;
   localparam int MaxKeySymbols = 12;
   localparam int RootState     = 1;
   localparam int RootBase      = 2;
   localparam int MinShift      = 2;
   localparam int CountMax      = 2047;
   localparam int BaseMax       = 65535;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_DUP       = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      MODE_INSERT = 1'b0,
      MODE_LOOKUP = 1'b1
   } mode_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_STEP, S_STEP_W, S_NEXT,
      S_COL, S_COL_W, S_FS, S_FK, S_FK_W, S_FB,
      S_MK, S_MK_W, S_MB, S_MZ, S_MS, S_MS_W, S_MO, S_MO_W, S_FIN
   } state_type;

   typedef struct packed {
      logic base_we;
      logic check_we;
      logic kid_we;
   } mem_ctl_type;

endpackage
`default_nettype wire

// File: hw/rtl/dte_ram.sv
`default_nettype none
module dte_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// File: hw/rtl/dte_seq.sv
`default_nettype none
module dte_seq #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_mode,
   input  wire logic [dte_pkg::KeyW-1:0]         req_key_codes,
   input  wire logic [dte_pkg::LenW-1:0]         req_key_length,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [dte_pkg::ValueW-1:0]            rsp_value,
   output logic [1:0]                            rsp_status,
   output dte_pkg::mem_ctl_type                  mem_ctl,
   output logic [$clog2(TABLE_DEPTH)-1:0]        base_waddr,
   output logic [dte_pkg::BaseW-1:0]             base_wdata,
   output logic [$clog2(TABLE_DEPTH)-1:0]        base_raddr,
   input  wire logic [dte_pkg::BaseW-1:0]        base_rdata,
   output logic [$clog2(TABLE_DEPTH)-1:0]        check_waddr,
   output logic [$clog2(TABLE_DEPTH)-1:0]        check_wdata,
   output logic [$clog2(TABLE_DEPTH)-1:0]        check_raddr,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0]   check_rdata,
   output logic [$clog2(TABLE_DEPTH)-1:0]        kid_waddr,
   output logic [$clog2(TABLE_DEPTH)-1:0]        kid_wdata,
   output logic [$clog2(TABLE_DEPTH)-1:0]        kid_raddr,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0]   kid_rdata
);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam logic [AW-1:0] LastIdx   = AW'(TABLE_DEPTH - 1);
   localparam logic [AW:0]   DepthW    = (AW+1)'(TABLE_DEPTH);
   localparam logic [16:0]   DepthX    = 17'(TABLE_DEPTH);
   localparam logic [AW-1:0] RootIdx   = AW'(dte_pkg::RootState);

   dte_pkg::state_type state_ff, state_in;
   logic [AW-1:0]               clr_ff, clr_in;
   logic                        mode_ff, mode_in;
   logic [dte_pkg::KeyW-1:0]    codes_ff, codes_in;
   logic [dte_pkg::LenW-1:0]    len_ff, len_in;
   logic [AW-1:0]               cur_ff, cur_in;
   logic [dte_pkg::LenW-1:0]    i_ff, i_in;
   logic [AW-1:0]               next_ff, next_in;
   logic [AW:0]                 moves_ff, moves_in;
   logic [dte_pkg::ValueW-1:0]  kc_ff, kc_in;
   logic [AW-1:0]               owner_ff, owner_in;
   logic [AW-1:0]               n_ff, n_in;
   logic [AW-1:0]               scan_ff, scan_in;
   logic [AW:0]                 t_ff, t_in;
   logic [AW-1:0]               k_ff, k_in;
   logic [AW-1:0]               old_ff, old_in;
   logic [AW-1:0]               ns_ff, ns_in;
   logic [dte_pkg::ValueW-1:0]  val_ff, val_in;
   dte_pkg::status_type         st_ff, st_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [dte_pkg::ValueW-1:0]  rsp_value_ff, rsp_value_in;
   logic [1:0]                  rsp_status_ff, rsp_status_in;

   logic [dte_pkg::SymW-1:0] code_c;
   logic [16:0]              nx_c;
   logic [AW:0]              fns_c;
   logic [AW:0]              kinc_c;
   logic [AW:0]              ncnt_c;
   logic                     bad_c;

   always_comb begin
      code_c = (i_ff < len_ff) ? codes_ff[dte_pkg::SymW*i_ff +: dte_pkg::SymW]
                               : '0;
      nx_c   = {1'b0, base_rdata} + 17'(code_c);
      fns_c  = {1'b0, kid_rdata} + t_ff;
      kinc_c = {1'b0, k_ff} + 1'b1;
      ncnt_c = {1'b0, n_ff} + ((check_rdata == owner_ff) ? 1'b1 : 1'b0);
      bad_c  = (req_key_length == '0) ||
               (req_key_length > dte_pkg::LenW'(dte_pkg::MaxKeySymbols));
      for (int j = 0; j < dte_pkg::MaxKeySymbols; j++) begin
         if ((dte_pkg::LenW'(j) < req_key_length) &&
             (req_key_codes[dte_pkg::SymW*j +: dte_pkg::SymW] == '0)) begin
            bad_c = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;  clr_in = clr_ff;    mode_in = mode_ff;
      codes_in = codes_ff;  len_in = len_ff;    cur_in = cur_ff;
      i_in = i_ff;          next_in = next_ff;  moves_in = moves_ff;
      kc_in = kc_ff;        owner_in = owner_ff; n_in = n_ff;
      scan_in = scan_ff;    t_in = t_ff;        k_in = k_ff;
      old_in = old_ff;      ns_in = ns_ff;      val_in = val_ff;
      st_in = st_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      mem_ctl     = '0;
      base_waddr  = '0;  base_wdata = '0;  base_raddr = '0;
      check_waddr = '0;  check_wdata = '0; check_raddr = '0;
      kid_waddr   = '0;  kid_wdata = '0;   kid_raddr = '0;
      req_stall   = 1'b1;

      unique case (state_ff)
         dte_pkg::S_CLEAR: begin
            mem_ctl.base_we  = 1'b1;
            mem_ctl.check_we = 1'b1;
            base_waddr  = clr_ff;
            check_waddr = clr_ff;
            base_wdata  = (clr_ff == RootIdx) ? dte_pkg::BaseW'(dte_pkg::RootBase) : '0;
            if (clr_ff == LastIdx) begin
               state_in = dte_pkg::S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         dte_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               mode_in  = req_mode;
               codes_in = req_key_codes;
               len_in   = req_key_length;
               cur_in   = RootIdx;
               i_in     = '0;
               moves_in = '0;
               val_in   = '0;
               if (bad_c) begin
                  st_in    = dte_pkg::ST_NOT_FOUND;
                  state_in = dte_pkg::S_FIN;
               end else begin
                  state_in = dte_pkg::S_STEP;
               end
            end
         end
         dte_pkg::S_STEP: begin
            base_raddr = cur_ff;
            state_in   = dte_pkg::S_STEP_W;
         end
         dte_pkg::S_STEP_W: begin
            next_in     = nx_c[AW-1:0];
            base_raddr  = nx_c[AW-1:0];
            check_raddr = nx_c[AW-1:0];
            if (nx_c >= DepthX) begin
               st_in = (mode_ff == dte_pkg::MODE_LOOKUP) ? dte_pkg::ST_NOT_FOUND
                                                        : dte_pkg::ST_FULL;
               state_in = dte_pkg::S_FIN;
            end else begin
               state_in = dte_pkg::S_NEXT;
            end
         end
         dte_pkg::S_NEXT: begin
            if (mode_ff == dte_pkg::MODE_LOOKUP) begin
               if (base_rdata == '0 || check_rdata != cur_ff) begin
                  st_in    = dte_pkg::ST_NOT_FOUND;
                  state_in = dte_pkg::S_FIN;
               end else if (code_c == '0) begin
                  st_in    = dte_pkg::ST_OK;
                  val_in   = base_rdata[dte_pkg::ValueW-1:0];
                  state_in = dte_pkg::S_FIN;
               end else begin
                  cur_in   = next_ff;
                  i_in     = i_ff + 1'b1;
                  state_in = dte_pkg::S_STEP;
               end
            end else if (base_rdata == '0) begin
               // free slot: attach tail or inner state
               if (code_c == '0) begin
                  if (kc_ff >= dte_pkg::ValueW'(dte_pkg::CountMax)) begin
                     st_in = dte_pkg::ST_FULL;
                  end else begin
                     kc_in = kc_ff + 1'b1;
                     mem_ctl.base_we  = 1'b1;
                     mem_ctl.check_we = 1'b1;
                     base_waddr  = next_ff;
                     base_wdata  = dte_pkg::BaseW'(kc_ff + 1'b1);
                     check_waddr = next_ff;
                     check_wdata = cur_ff;
                     val_in = kc_ff + 1'b1;
                     st_in  = dte_pkg::ST_OK;
                  end
                  state_in = dte_pkg::S_FIN;
               end else if ((17'(next_ff) + 17'd1) > 17'(dte_pkg::BaseMax)) begin
                  st_in    = dte_pkg::ST_FULL;
                  state_in = dte_pkg::S_FIN;
               end else begin
                  mem_ctl.base_we  = 1'b1;
                  mem_ctl.check_we = 1'b1;
                  base_waddr  = next_ff;
                  base_wdata  = dte_pkg::BaseW'(17'(next_ff) + 17'd1);
                  check_waddr = next_ff;
                  check_wdata = cur_ff;
                  cur_in   = next_ff;
                  i_in     = i_ff + 1'b1;
                  state_in = dte_pkg::S_STEP;
               end
            end else if (check_rdata != cur_ff) begin
               // collision: relocate the owner's children
               owner_in = check_rdata;
               if (check_rdata == '0 || moves_ff >= DepthW) begin
                  st_in    = dte_pkg::ST_FULL;
                  state_in = dte_pkg::S_FIN;
               end else begin
                  scan_in  = AW'(1);
                  n_in     = '0;
                  state_in = dte_pkg::S_COL;
               end
            end else if (code_c == '0) begin
               st_in    = dte_pkg::ST_DUP;
               val_in   = base_rdata[dte_pkg::ValueW-1:0];
               state_in = dte_pkg::S_FIN;
            end else begin
               cur_in   = next_ff;
               i_in     = i_ff + 1'b1;
               state_in = dte_pkg::S_STEP;
            end
         end
         dte_pkg::S_COL: begin
            check_raddr = scan_ff;
            state_in    = dte_pkg::S_COL_W;
         end
         dte_pkg::S_COL_W: begin
            if (check_rdata == owner_ff) begin
               mem_ctl.kid_we = 1'b1;
               kid_waddr = n_ff;
               kid_wdata = scan_ff;
            end
            n_in = ncnt_c[AW-1:0];
            if (scan_ff == LastIdx) begin
               if (ncnt_c == '0) begin
                  st_in    = dte_pkg::ST_FULL;
                  state_in = dte_pkg::S_FIN;
               end else begin
                  t_in     = (AW+1)'(dte_pkg::MinShift);
                  state_in = dte_pkg::S_FS;
               end
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = dte_pkg::S_COL;
            end
         end
         dte_pkg::S_FS: begin
            k_in = '0;
            if (t_ff >= DepthW) begin
               st_in    = dte_pkg::ST_FULL;
               state_in = dte_pkg::S_FIN;
            end else begin
               state_in = dte_pkg::S_FK;
            end
         end
         dte_pkg::S_FK: begin
            kid_raddr = k_ff;
            state_in  = dte_pkg::S_FK_W;
         end
         dte_pkg::S_FK_W: begin
            base_raddr = fns_c[AW-1:0];
            if (fns_c >= DepthW || fns_c[AW-1:0] == next_ff) begin
               t_in     = t_ff + 1'b1;
               state_in = dte_pkg::S_FS;
            end else begin
               state_in = dte_pkg::S_FB;
            end
         end
         dte_pkg::S_FB: begin
            if (base_rdata != '0) begin
               t_in     = t_ff + 1'b1;
               state_in = dte_pkg::S_FS;
            end else if (kinc_c == {1'b0, n_ff}) begin
               k_in     = '0;
               state_in = dte_pkg::S_MK;
            end else begin
               k_in     = kinc_c[AW-1:0];
               state_in = dte_pkg::S_FK;
            end
         end
         dte_pkg::S_MK: begin
            kid_raddr = k_ff;
            state_in  = dte_pkg::S_MK_W;
         end
         dte_pkg::S_MK_W: begin
            old_in     = kid_rdata;
            ns_in      = fns_c[AW-1:0];
            base_raddr = kid_rdata;
            state_in   = dte_pkg::S_MB;
         end
         dte_pkg::S_MB: begin
            mem_ctl.base_we  = 1'b1;
            mem_ctl.check_we = 1'b1;
            base_waddr  = ns_ff;
            base_wdata  = base_rdata;
            check_waddr = ns_ff;
            check_wdata = owner_ff;
            state_in    = dte_pkg::S_MZ;
         end
         dte_pkg::S_MZ: begin
            mem_ctl.base_we  = 1'b1;
            mem_ctl.check_we = 1'b1;
            base_waddr  = old_ff;
            check_waddr = old_ff;
            scan_in     = AW'(1);
            state_in    = dte_pkg::S_MS;
         end
         dte_pkg::S_MS: begin
            check_raddr = scan_ff;
            state_in    = dte_pkg::S_MS_W;
         end
         dte_pkg::S_MS_W: begin
            if (check_rdata == old_ff) begin
               mem_ctl.check_we = 1'b1;
               check_waddr = scan_ff;
               check_wdata = ns_ff;
            end
            if (scan_ff == LastIdx) begin
               if (kinc_c == {1'b0, n_ff}) begin
                  state_in = dte_pkg::S_MO;
               end else begin
                  k_in     = kinc_c[AW-1:0];
                  state_in = dte_pkg::S_MK;
               end
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = dte_pkg::S_MS;
            end
         end
         dte_pkg::S_MO: begin
            base_raddr = owner_ff;
            state_in   = dte_pkg::S_MO_W;
         end
         dte_pkg::S_MO_W: begin
            mem_ctl.base_we = 1'b1;
            base_waddr = owner_ff;
            base_wdata = base_rdata + dte_pkg::BaseW'(t_ff);
            moves_in   = moves_ff + 1'b1;
            cur_in     = RootIdx;
            i_in       = '0;
            state_in   = dte_pkg::S_STEP;
         end
         dte_pkg::S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = val_ff;
               rsp_status_in = st_ff;
               state_in      = dte_pkg::S_IDLE;
            end
         end
         default: state_in = dte_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dte_pkg::S_CLEAR;
         clr_ff       <= '0;
         kc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         kc_ff        <= kc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;    codes_ff <= codes_in;  len_ff <= len_in;
      cur_ff <= cur_in;      i_ff <= i_in;          next_ff <= next_in;
      moves_ff <= moves_in;  owner_ff <= owner_in;  n_ff <= n_in;
      scan_ff <= scan_in;    t_ff <= t_in;          k_ff <= k_in;
      old_ff <= old_in;      ns_ff <= ns_in;        val_ff <= val_in;
      st_ff <= st_in;        rsp_value_ff <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
endmodule
`default_nettype wire

// File: hw/rtl/double_array_trie_engine_unit.sv
// Double-array trie engine: stores keys of 5-bit symbols and looks them up.
// Input channel (req_*): one transaction per key with mode (insert or
//   look up), up to 12 packed symbol codes (first symbol lowest) and length.
// Result channel (rsp_*): exactly one transaction per input with the value
//   and a status (ok, not found, duplicate key, table full).
// Walk: each walk step reads the base of the current state, then the base
//   and check of the next slot. A key of L symbols takes L+1 steps with the
//   tail; a malformed key skips the walk. An insert without collision walks
//   the same steps. A collision runs a relocation on the shared stores: it
//   collects the children, tries shifts upward and tests the children against
//   each, moves each child (copying its slot, clearing the old one and
//   repointing its own children) and raises the parent's base, then the walk
//   restarts. Each store has one read port; one key is in flight at a time.
// Reset: a clearing pass over all TABLE_DEPTH slots writes the empty trie
//   (root base 2); req_stall stays high until it ends.
// Stall: a finished result sits in an output register; the engine accepts a
//   new key while it waits, and holds the next result until the slot frees.
`default_nettype none
module double_array_trie_engine_unit #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_mode,
   input  wire logic [dte_pkg::KeyW-1:0]      req_key_codes,
   input  wire logic [dte_pkg::LenW-1:0]      req_key_length,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [dte_pkg::ValueW-1:0]         rsp_value,
   output logic [1:0]                         rsp_status
);
   localparam int AW = $clog2(TABLE_DEPTH);

   dte_pkg::mem_ctl_type      mem_ctl;
   logic [AW-1:0]             base_waddr, base_raddr;
   logic [dte_pkg::BaseW-1:0] base_wdata, base_rdata;
   logic [AW-1:0]             check_waddr, check_wdata, check_raddr, check_rdata;
   logic [AW-1:0]             kid_waddr, kid_wdata, kid_raddr, kid_rdata;

   // Sequencer: walks the trie and runs relocations on the shared stores
   dte_seq #(.TABLE_DEPTH(TABLE_DEPTH)) u_seq (
      .clock, .reset,
      .req_valid, .req_stall, .req_mode, .req_key_codes, .req_key_length,
      .rsp_valid, .rsp_stall, .rsp_value, .rsp_status,
      .mem_ctl,
      .base_waddr, .base_wdata, .base_raddr, .base_rdata,
      .check_waddr, .check_wdata, .check_raddr, .check_rdata,
      .kid_waddr, .kid_wdata, .kid_raddr, .kid_rdata
   );

   // Base store: next-state offset per slot, tail slots hold the key value
   dte_ram #(.WIDTH(dte_pkg::BaseW), .DEPTH(TABLE_DEPTH)) u_base (
      .clock, .we(mem_ctl.base_we), .waddr(base_waddr), .wdata(base_wdata),
      .raddr(base_raddr), .rdata(base_rdata)
   );

   // Check store: parent of each slot
   dte_ram #(.WIDTH(AW), .DEPTH(TABLE_DEPTH)) u_check (
      .clock, .we(mem_ctl.check_we), .waddr(check_waddr), .wdata(check_wdata),
      .raddr(check_raddr), .rdata(check_rdata)
   );

   // Child list of the parent being relocated, in ascending slot order
   dte_ram #(.WIDTH(AW), .DEPTH(TABLE_DEPTH)) u_kid (
      .clock, .we(mem_ctl.kid_we), .waddr(kid_waddr), .wdata(kid_wdata),
      .raddr(kid_raddr), .rdata(kid_rdata)
   );

   // Input stalls after an accept: the engine holds one key at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted twice in a row");

   // Input is stalled after each reset cycle, as the clearing pass begins
   a_clear_blocks: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input open right after reset");

   // Advance only zero values with not found or full
   a_err_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == dte_pkg::ST_NOT_FOUND ||
                     rsp_status == dte_pkg::ST_FULL)) |-> (rsp_value == '0))
      else $error("nonzero value on error status");
endmodule
`default_nettype wire

// File: test/double_array_trie_engine_unit_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module double_array_trie_engine_unit_tb;

   localparam int Depth      = 1024;
   localparam int IdleLimit  = 4000000;
   localparam int PoolSize   = 40;
   localparam int LongHold   = 400;

   typedef struct {
      dte_pkg::mode_type            mode;
      logic [dte_pkg::KeyW-1:0]     codes;
      logic [dte_pkg::LenW-1:0]     len;
      bit         drain;   // hold this key back until every result is in
   } key_txn_type;

   typedef struct {
      logic [dte_pkg::ValueW-1:0] value;
      dte_pkg::status_type        status;
   } trie_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_mode = 1'b0;
   logic [dte_pkg::KeyW-1:0] req_key_codes = '0;
   logic [dte_pkg::LenW-1:0] req_key_length = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [dte_pkg::ValueW-1:0] rsp_value;
   logic [1:0] rsp_status;

   key_txn_type     pending_keys[$];
   trie_result_type expected_results[$];
   logic [dte_pkg::KeyW-1:0] key_pool[PoolSize];
   logic [dte_pkg::LenW-1:0] len_pool[PoolSize];

   // Shadow copy of the trie
   int unsigned base_mirror[Depth];
   int unsigned check_mirror[Depth];
   int unsigned keys_stored;

   bit failed = 1'b0;
   int sent_count = 0;
   int idle_cycles = 0;
   bit quiet_tail = 1'b0;
   bit long_hold_done = 1'b0;

   double_array_trie_engine_unit #(.TABLE_DEPTH(Depth)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_key_codes(req_key_codes), .req_key_length(req_key_length),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_value(rsp_value), .rsp_status(rsp_status)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int unsigned symbol_of(logic [dte_pkg::KeyW-1:0] codes, int i);
      return 32'((codes >> (dte_pkg::SymW * i)) & 60'd31);
   endfunction

   // Walk the shadow trie from the root; mirrors the engine's insert with
   // relocation of a colliding parent's children.
   function automatic trie_result_type trie_insert(logic [dte_pkg::KeyW-1:0] codes,
                                                   int len);
      trie_result_type r;
      int unsigned cur, code, nxt, owner, shift, ns, old;
      int unsigned kids[Depth];
      int i, moves, nkids;
      bit fits, found;
      r.value = '0;
      r.status = dte_pkg::ST_FULL;
      cur = dte_pkg::RootState;
      i = 0;
      moves = 0;
      while (i <= len) begin
         code = (i < len) ? symbol_of(codes, i) : 0;
         nxt = base_mirror[cur] + code;
         if (nxt >= Depth) return r;
         if (base_mirror[nxt] == 0) begin
            if (code == 0) begin
               if (keys_stored >= dte_pkg::CountMax) return r;
               keys_stored++;
               base_mirror[nxt] = keys_stored;
               check_mirror[nxt] = cur;
               r.value = dte_pkg::ValueW'(keys_stored);
               r.status = dte_pkg::ST_OK;
               return r;
            end
            if (nxt + 1 > dte_pkg::BaseMax) return r;
            base_mirror[nxt] = nxt + 1;
            check_mirror[nxt] = cur;
         end else if (check_mirror[nxt] != cur) begin
            owner = check_mirror[nxt];
            if (owner == 0 || owner >= Depth || moves >= Depth) return r;
            nkids = 0;
            for (int j = 1; j < Depth; j++)
               if (check_mirror[j] == owner) kids[nkids++] = j;
            if (nkids == 0) return r;
            found = 1'b0;
            shift = 0;
            for (int t = dte_pkg::MinShift; t < Depth && !found; t++) begin
               fits = 1'b1;
               for (int k = 0; k < nkids && fits; k++) begin
                  ns = kids[k] + t;
                  if (ns >= Depth || ns == nxt || base_mirror[ns] != 0) fits = 1'b0;
               end
               if (fits) begin
                  found = 1'b1;
                  shift = t;
               end
            end
            if (!found) return r;
            for (int k = 0; k < nkids; k++) begin
               old = kids[k];
               ns = old + shift;
               base_mirror[ns] = base_mirror[old];
               check_mirror[ns] = owner;
               base_mirror[old] = 0;
               check_mirror[old] = 0;
               for (int j = 1; j < Depth; j++)
                  if (check_mirror[j] == old) check_mirror[j] = ns;
            end
            base_mirror[owner] = (base_mirror[owner] + shift) & dte_pkg::BaseMax;
            moves++;
            cur = dte_pkg::RootState;
            i = 0;
            continue;
         end else if (code == 0) begin
            r.value = dte_pkg::ValueW'(base_mirror[nxt]);
            r.status = dte_pkg::ST_DUP;
            return r;
         end
         cur = nxt;
         i++;
      end
      return r;
   endfunction

   function automatic trie_result_type trie_lookup(logic [dte_pkg::KeyW-1:0] codes,
                                                   int len);
      trie_result_type r;
      int unsigned cur, code, nxt;
      r.value = '0;
      r.status = dte_pkg::ST_NOT_FOUND;
      cur = dte_pkg::RootState;
      for (int i = 0; i <= len; i++) begin
         code = (i < len) ? symbol_of(codes, i) : 0;
         nxt = base_mirror[cur] + code;
         if (nxt >= Depth || base_mirror[nxt] == 0 || check_mirror[nxt] != cur)
            return r;
         if (code == 0) begin
            r.value = dte_pkg::ValueW'(base_mirror[nxt]);
            r.status = dte_pkg::ST_OK;
            return r;
         end
         cur = nxt;
      end
      return r;
   endfunction

   function automatic trie_result_type trie_apply(key_txn_type k);
      trie_result_type r;
      bit bad;
      r.value = '0;
      r.status = dte_pkg::ST_NOT_FOUND;
      bad = (k.len == 0 || k.len > dte_pkg::MaxKeySymbols);
      for (int i = 0; !bad && i < k.len; i++)
         if (symbol_of(k.codes, i) == 0) bad = 1'b1;
      if (bad) return r;
      if (k.mode == dte_pkg::MODE_INSERT) return trie_insert(k.codes, k.len);
      return trie_lookup(k.codes, k.len);
   endfunction

   function automatic logic [dte_pkg::KeyW-1:0] repeat_symbol(int sym, int len);
      logic [dte_pkg::KeyW-1:0] c;
      c = '0;
      for (int i = 0; i < len; i++) c |= dte_pkg::KeyW'(sym) << (dte_pkg::SymW * i);
      return c;
   endfunction

   function automatic logic [dte_pkg::KeyW-1:0] random_key(int len);
      logic [dte_pkg::KeyW-1:0] c;
      int sym;
      c = '0;
      for (int i = 0; i < len; i++) begin
         // small alphabet mostly, so keys share prefixes and collide
         sym = ($urandom_range(4) != 0) ? $urandom_range(1, 3) : $urandom_range(1, 31);
         c |= dte_pkg::KeyW'(sym) << (dte_pkg::SymW * i);
      end
      return c;
   endfunction

   task automatic queue_key(dte_pkg::mode_type m, logic [dte_pkg::KeyW-1:0] c, int len,
                            bit drain = 1'b0);
      key_txn_type k;
      k.mode = m;
      k.codes = c;
      k.len = dte_pkg::LenW'(len);
      k.drain = drain;
      pending_keys.push_back(k);
   endtask

   // Stimulus: directed corner cases, then pool-driven random traffic
   initial begin
      int sel, pick, len;
      for (int i = 0; i < Depth; i++) begin
         base_mirror[i] = 0;
         check_mirror[i] = 0;
      end
      base_mirror[dte_pkg::RootState] = dte_pkg::RootBase;
      keys_stored = 0;

      queue_key(dte_pkg::MODE_LOOKUP, repeat_symbol(1, 1), 1);     // empty trie miss
      queue_key(dte_pkg::MODE_INSERT, repeat_symbol(1, 1), 1);
      queue_key(dte_pkg::MODE_INSERT, repeat_symbol(2, 1), 1);     // collides with tail of "1"
      queue_key(dte_pkg::MODE_INSERT, repeat_symbol(1, 1), 1);     // duplicate
      queue_key(dte_pkg::MODE_LOOKUP, repeat_symbol(1, 1), 1);
      queue_key(dte_pkg::MODE_LOOKUP, repeat_symbol(2, 1), 1);
      queue_key(dte_pkg::MODE_INSERT, repeat_symbol(31, 1), 1);
      queue_key(dte_pkg::MODE_INSERT, repeat_symbol(31, 12), 12);  // longest key
      queue_key(dte_pkg::MODE_LOOKUP, repeat_symbol(31, 12), 12);
      queue_key(dte_pkg::MODE_LOOKUP, repeat_symbol(31, 11), 11);  // prefix only: miss
      queue_key(dte_pkg::MODE_INSERT, repeat_symbol(1, 3), 3);
      queue_key(dte_pkg::MODE_LOOKUP, repeat_symbol(1, 2), 2);
      queue_key(dte_pkg::MODE_INSERT, '0, 0);                       // zero length
      queue_key(dte_pkg::MODE_LOOKUP, '0, 0);
      queue_key(dte_pkg::MODE_INSERT, repeat_symbol(5, 13), 13);   // too long
      queue_key(dte_pkg::MODE_LOOKUP, '1, 15);
      queue_key(dte_pkg::MODE_INSERT, 60'h0000_0000_0000_401, 3);  // zero symbol inside
      queue_key(dte_pkg::MODE_LOOKUP, 60'h0000_0000_0000_401, 3);
      queue_key(dte_pkg::MODE_INSERT, '1, 12);                      // all ones
      queue_key(dte_pkg::MODE_LOOKUP, '1, 12);
      queue_key(dte_pkg::MODE_INSERT, repeat_symbol(3, 2), 2, 1'b1);
      queue_key(dte_pkg::MODE_LOOKUP, repeat_symbol(2, 1), 1);

      for (int i = 0; i < PoolSize; i++) begin
         sel = $urandom_range(19);
         len = (sel < 14) ? $urandom_range(1, 3) : (sel < 19) ? $urandom_range(4, 6) : 12;
         len_pool[i] = dte_pkg::LenW'(len);
         key_pool[i] = random_key(len);
      end

      for (int n = 0; n < 1300; n++) begin
         if ($urandom_range(6) == 0) begin
            // noise: any bits, any length
            queue_key(dte_pkg::mode_type'($urandom_range(1)),
                      dte_pkg::KeyW'({$urandom, $urandom}),
                      $urandom_range(15), (n % 400) == 399);
         end else begin
            pick = $urandom_range(PoolSize - 1);
            queue_key(dte_pkg::mode_type'($urandom_range(1)), key_pool[pick],
                      len_pool[pick], (n % 400) == 399);
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      wait (pending_keys.size() == 0 && !req_valid && expected_results.size() == 0);
      repeat (50) @(posedge clock);
      if (!failed && expected_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Driver: offer keys, hold while stalled, idle in short bursts
   always @(posedge clock) begin
      int gap;
      key_txn_type k;
      if (reset) begin
         req_valid <= 1'b0;
         gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            k.mode = dte_pkg::mode_type'(req_mode);
            k.codes = req_key_codes;
            k.len = req_key_length;
            expected_results.push_back(trie_apply(k));
            sent_count++;
            quiet_tail = pending_keys.size() < 150;
            gap = (!quiet_tail && $urandom_range(4) == 0) ? $urandom_range(1, 4) : 0;
         end
         if (req_valid && req_stall) begin
            // hold the offered transaction
         end else if (gap > 0) begin
            gap--;
            req_valid <= 1'b0;
         end else if (pending_keys.size() > 0 &&
                      !(pending_keys[0].drain && expected_results.size() != 0)) begin
            k = pending_keys.pop_front();
            req_valid <= 1'b1;
            req_mode <= k.mode;
            req_key_codes <= k.codes;
            req_key_length <= k.len;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: check each result against the oldest expectation, stall at random
   always @(posedge clock) begin
      int burst;
      int long_left;
      trie_result_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
         burst = 0;
         long_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result: value %0d status %0d", rsp_value, rsp_status);
               failed = 1'b1;
            end else begin
               e = expected_results.pop_front();
               if (rsp_value !== e.value) begin
                  $error("value: expected %0d, actual %0d", e.value, rsp_value);
                  failed = 1'b1;
               end
               if (rsp_status !== e.status) begin
                  $error("status: expected %0d, actual %0d", e.status, rsp_status);
                  failed = 1'b1;
               end
            end
         end
         // one long back-pressure stretch to fill the engine up
         if (!long_hold_done && sent_count >= 300) begin
            long_hold_done = 1'b1;
            long_left = LongHold;
         end
         if (long_left > 0) begin
            long_left--;
            rsp_stall <= 1'b1;
         end else if (burst > 0) begin
            burst--;
            rsp_stall <= 1'b1;
         end else if (!quiet_tail && $urandom_range(5) == 0) begin
            burst = $urandom_range(0, 3);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: advance while transactions keep moving
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
`default_nettype wire

// File: sim.f
hw/rtl/dte_pkg.sv
hw/rtl/dte_ram.sv
hw/rtl/dte_seq.sv
hw/rtl/double_array_trie_engine_unit.sv
test/double_array_trie_engine_unit_tb.sv
